FILE: rtl/core/mme_pkg.sv
package mme_pkg;

   localparam int MAX_DIM = 8;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DATA_W  = 32;
   localparam int DIM_W   = 4;
   localparam int REG_W   = 3;

   typedef enum logic [1:0] {
      CMD_WRITE_A = 2'd0,
      CMD_WRITE_B = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [REG_W-1:0] {
      REG_ROWS_A = 3'd0,
      REG_COLS_A = 3'd1,
      REG_ROWS_B = 3'd2,
      REG_COLS_B = 3'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic              wr_a;
      logic              wr_b;
      logic              rd_en;
      logic              rd_first;
      logic              rd_last;
      logic [ADDR_W-1:0] rd_a_addr;
      logic [ADDR_W-1:0] rd_b_addr;
      logic              load_out;
      logic              load_err;
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic              out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic acc_ready;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/mme_ctrl.sv
module mme_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mme_pkg::cmd_type             req_command,
   input  logic                         csr_we,
   input  logic [mme_pkg::REG_W-1:0]    csr_index,
   input  logic [mme_pkg::DIM_W-1:0]    csr_wdata,
   input  mme_pkg::dp_status_type       status,
   output mme_pkg::dp_cmd_type          cmd
);

   mme_pkg::state_type state_ff, state_in;
   logic [mme_pkg::IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [mme_pkg::DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   logic [mme_pkg::IDX_W-1:0] m1, n1, q1;
   logic                      mismatch;
   logic                      accept;
   logic                      final_elem;

   function automatic logic [mme_pkg::DIM_W-1:0] eff_dim(input logic [mme_pkg::DIM_W-1:0] v);
      logic [mme_pkg::DIM_W-1:0] r;
      if (v == '0) begin
         r = mme_pkg::DIM_W'(1);
      end else if (v > mme_pkg::DIM_W'(mme_pkg::MAX_DIM)) begin
         r = mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign m1 = mme_pkg::IDX_W'(eff_dim(rows_a_ff) - mme_pkg::DIM_W'(1));
   assign n1 = mme_pkg::IDX_W'(eff_dim(cols_a_ff) - mme_pkg::DIM_W'(1));
   assign q1 = mme_pkg::IDX_W'(eff_dim(cols_b_ff) - mme_pkg::DIM_W'(1));
   assign mismatch   = eff_dim(rows_b_ff) != eff_dim(cols_a_ff);
   assign req_ready  = state_ff == mme_pkg::ST_IDLE;
   assign accept     = req_valid && req_ready;
   assign final_elem = (i_ff == m1) && (j_ff == q1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= mme_pkg::DIM_W'(1);
         cols_a_ff <= mme_pkg::DIM_W'(1);
         rows_b_ff <= mme_pkg::DIM_W'(1);
         cols_b_ff <= mme_pkg::DIM_W'(1);
      end else if (csr_we) begin
         case (mme_pkg::reg_index_type'(csr_index))
            mme_pkg::REG_ROWS_A: rows_a_ff <= csr_wdata;
            mme_pkg::REG_COLS_A: cols_a_ff <= csr_wdata;
            mme_pkg::REG_ROWS_B: rows_b_ff <= csr_wdata;
            mme_pkg::REG_COLS_B: cols_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (accept && req_command == mme_pkg::CMD_COMPUTE) begin
               i_in = '0;
               j_in = '0;
               k_in = '0;
               state_in = mismatch ? mme_pkg::ST_ERROR : mme_pkg::ST_ISSUE;
            end
         end
         mme_pkg::ST_ISSUE: begin
            if (k_ff == n1) begin
               k_in     = '0;
               state_in = mme_pkg::ST_WAIT;
            end else begin
               k_in = k_ff + mme_pkg::IDX_W'(1);
            end
         end
         mme_pkg::ST_WAIT: begin
            if (status.acc_ready && status.out_free) begin
               if (final_elem) begin
                  state_in = mme_pkg::ST_IDLE;
               end else begin
                  state_in = mme_pkg::ST_ISSUE;
                  if (j_ff == q1) begin
                     j_in = '0;
                     i_in = i_ff + mme_pkg::IDX_W'(1);
                  end else begin
                     j_in = j_ff + mme_pkg::IDX_W'(1);
                  end
               end
            end
         end
         mme_pkg::ST_ERROR: begin
            if (status.out_free) begin
               state_in = mme_pkg::ST_IDLE;
            end
         end
         default: state_in = mme_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.rd_a_addr = {i_ff, k_ff};
      cmd.rd_b_addr = {k_ff, j_ff};
      cmd.rd_first  = k_ff == '0;
      cmd.rd_last   = k_ff == n1;
      cmd.out_row   = i_ff;
      cmd.out_col   = j_ff;
      cmd.out_last  = final_elem;
      case (state_ff)
         mme_pkg::ST_IDLE: begin
            cmd.wr_a = accept && req_command == mme_pkg::CMD_WRITE_A;
            cmd.wr_b = accept && req_command == mme_pkg::CMD_WRITE_B;
         end
         mme_pkg::ST_ISSUE: cmd.rd_en    = 1'b1;
         mme_pkg::ST_WAIT:  cmd.load_out = status.acc_ready && status.out_free;
         mme_pkg::ST_ERROR: cmd.load_err = status.out_free;
         default: ;
      endcase
   end

endmodule

FILE: rtl/core/mme_datapath.sv
module mme_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mme_pkg::dp_cmd_type           cmd,
   output mme_pkg::dp_status_type        status,
   input  logic [mme_pkg::IDX_W-1:0]     wr_row,
   input  logic [mme_pkg::IDX_W-1:0]     wr_col,
   input  logic [mme_pkg::DATA_W-1:0]    wr_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mme_pkg::IDX_W-1:0]     rsp_row,
   output logic [mme_pkg::IDX_W-1:0]     rsp_col,
   output logic [mme_pkg::DATA_W-1:0]    rsp_value,
   output logic                          rsp_error,
   output logic                          rsp_last
);

   logic [mme_pkg::DATA_W-1:0] mem_a [mme_pkg::DEPTH];
   logic [mme_pkg::DATA_W-1:0] mem_b [mme_pkg::DEPTH];
   logic [mme_pkg::DATA_W-1:0] a_rd_ff, b_rd_ff, prod_ff, acc_ff, mul_lo;
   logic s1_valid_ff, s1_first_ff, s1_last_ff;
   logic s2_valid_ff, s2_first_ff, s2_last_ff;
   logic acc_ready_ff, acc_ready_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [mme_pkg::IDX_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic [mme_pkg::DATA_W-1:0] rsp_value_ff;
   logic rsp_error_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[{wr_row, wr_col}] <= wr_value;
      end
      if (cmd.wr_b) begin
         mem_b[{wr_row, wr_col}] <= wr_value;
      end
      a_rd_ff <= mem_a[cmd.rd_a_addr];
      b_rd_ff <= mem_b[cmd.rd_b_addr];
   end

   // low word of the product is the same for signed and unsigned operands
   assign mul_lo = a_rd_ff * b_rd_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_lo;
      if (s2_valid_ff) begin
         acc_ff <= s2_first_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_ready_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.rd_en;
         s2_valid_ff  <= s1_valid_ff;
         acc_ready_ff <= acc_ready_in;
      end
      s1_first_ff <= cmd.rd_first;
      s1_last_ff  <= cmd.rd_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
   end

   always_comb begin
      acc_ready_in = acc_ready_ff;
      if (s2_valid_ff && s2_last_ff) begin
         acc_ready_in = 1'b1;
      end else if (cmd.load_out) begin
         acc_ready_in = 1'b0;
      end
   end

   assign status.acc_ready = acc_ready_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out || cmd.load_err) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_out) begin
         rsp_row_ff   <= cmd.out_row;
         rsp_col_ff   <= cmd.out_col;
         rsp_value_ff <= acc_ff;
         rsp_error_ff <= 1'b0;
         rsp_last_ff  <= cmd.out_last;
      end else if (cmd.load_err) begin
         rsp_row_ff   <= '0;
         rsp_col_ff   <= '0;
         rsp_value_ff <= '0;
         rsp_error_ff <= 1'b1;
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;
   assign rsp_last  = rsp_last_ff;

   a_load_needs_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> acc_ready_ff)
      else $error("result loaded before dot product complete");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && acc_ready_ff))
      else $error("new element started before previous one was taken");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out || cmd.load_err) |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_out && cmd.load_err))
      else $error("element and error loaded together");

endmodule

FILE: rtl/core/matrix_multiply_engine.sv
// Matrix multiply engine, A (rows_a x cols_a) times B (rows_b x cols_b).
// Load requests (write A or B) are accepted back to back.
// Compute: each product element takes cols_a serial MAC reads through the
// single read port of each store, then multiply and add.
// A mismatch error result is loaded once the response slot is free. Synchronous reset
// clears control and sets all dimensions to 1; the stores are not cleared.
module matrix_multiply_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row[2:0], col[5:3], value[37:6], zero[39:38]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_row[2:0], out_col[5:3], product_value[37:6], zero[39:38]
   output logic        rsp_tuser,   // dim_error
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [mme_pkg::REG_W-1:0] csr_index,
   input  logic [mme_pkg::DIM_W-1:0] csr_wdata
);

   mme_pkg::dp_cmd_type    dp_cmd;
   mme_pkg::dp_status_type dp_status;
   logic [mme_pkg::IDX_W-1:0]  rsp_row, rsp_col;
   logic [mme_pkg::DATA_W-1:0] rsp_value;

   mme_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (mme_pkg::cmd_type'(req_tuser)),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .status      (dp_status),
      .cmd         (dp_cmd)
   );

   mme_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .wr_row    (req_tdata[2:0]),
      .wr_col    (req_tdata[5:3]),
      .wr_value  (req_tdata[37:6]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_value (rsp_value),
      .rsp_error (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_value, rsp_col, rsp_row};

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED      = 2'd3;
   localparam logic [2:0] REG_SPARE       = 3'd5;
   localparam int         FIRST_SPARE_REG = 4;
   localparam int         LAST_SPARE_REG  = 7;
   localparam int         TOTAL_REQUESTS  = 430;
   localparam int         DRAIN_CYCLES    = 12;
   localparam int         HOLD_AFTER      = 40;
   localparam int         HOLD_CYCLES     = 400;
   localparam int         CYCLE_LIMIT     = 2000000;

   typedef struct packed {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        err;
      logic        last;
   } product_type;

   // one line of the directed script; given marks a typed-in expected result
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  csr_sel;
      logic [3:0]  csr_data;
      logic [1:0]  cmd;
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] value;
      logic        given;
      logic [31:0] want_value;
      logic        want_err;
   } step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [mme_pkg::REG_W-1:0] csr_index;
   logic [mme_pkg::DIM_W-1:0] csr_wdata;

   matrix_multiply_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [31:0] a_words [mme_pkg::DEPTH];
   logic [31:0] b_words [mme_pkg::DEPTH];
   logic [3:0]  cfg_rows_a = 4'd1;
   logic [3:0]  cfg_cols_a = 4'd1;
   logic [3:0]  cfg_rows_b = 4'd1;
   logic [3:0]  cfg_cols_b = 4'd1;
   product_type expected_products [$];

   // stimulus bookkeeping: never read an entry that was never written
   bit          a_written [mme_pkg::DEPTH];
   bit          b_written [mme_pkg::DEPTH];
   int          requests_sent = 0;
   int          burst_left = 0;
   bit          failed = 0;
   step_type    script [$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(input logic [3:0] v);
      if (v == 4'd0) return 1;
      if (v > mme_pkg::MAX_DIM) return mme_pkg::MAX_DIM;
      return int'(v);
   endfunction

   task automatic predict_products(input logic [1:0] cmd, input logic [2:0] row,
                                   input logic [2:0] col, input logic [31:0] value);
      int          m, n, p, q;
      logic [31:0] acc;
      product_type item;
      case (cmd)
         mme_pkg::CMD_WRITE_A: a_words[row * mme_pkg::MAX_DIM + col] = value;
         mme_pkg::CMD_WRITE_B: b_words[row * mme_pkg::MAX_DIM + col] = value;
         mme_pkg::CMD_COMPUTE: begin
            m = eff_dim(cfg_rows_a);
            n = eff_dim(cfg_cols_a);
            p = eff_dim(cfg_rows_b);
            q = eff_dim(cfg_cols_b);
            if (p != n) begin
               item = '{row: 3'd0, col: 3'd0, value: 32'd0, err: 1'b1, last: 1'b1};
               expected_products.push_back(item);
            end else begin
               for (int i = 0; i < m; i++) begin
                  for (int j = 0; j < q; j++) begin
                     acc = 32'd0;
                     for (int k = 0; k < n; k++)
                        acc = acc + a_words[i * mme_pkg::MAX_DIM + k]
                                  * b_words[k * mme_pkg::MAX_DIM + j];
                     item.row   = 3'(i);
                     item.col   = 3'(j);
                     item.value = acc;
                     item.err   = 1'b0;
                     item.last  = (i == m - 1) && (j == q - 1);
                     expected_products.push_back(item);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 4);
      if (r < 9) return $urandom_range(5, 7);
      return mme_pkg::MAX_DIM;
   endfunction

   // register code for an effective size, using the aliases 0 and 9..15
   function automatic logic [3:0] dim_code(input int d);
      if (d == 1) return 4'($urandom_range(0, 1));
      if (d == mme_pkg::MAX_DIM) return 4'($urandom_range(mme_pkg::MAX_DIM, 15));
      return 4'(d);
   endfunction

   function automatic step_type csr_step(input logic [2:0] sel, input logic [3:0] data);
      step_type s;
      s = '0;
      s.is_csr   = 1'b1;
      s.csr_sel  = sel;
      s.csr_data = data;
      return s;
   endfunction

   function automatic step_type req_step(input logic [1:0] cmd, input logic [2:0] row,
                                         input logic [2:0] col, input logic [31:0] value);
      step_type s;
      s = '0;
      s.cmd   = cmd;
      s.row   = row;
      s.col   = col;
      s.value = value;
      return s;
   endfunction

   function automatic step_type check_step(input logic [31:0] want_value,
                                           input logic want_err);
      step_type s;
      s = '0;
      s.cmd        = mme_pkg::CMD_COMPUTE;
      s.given      = 1'b1;
      s.want_value = want_value;
      s.want_err   = want_err;
      return s;
   endfunction

   task automatic write_csr(input logic [2:0] index, input logic [3:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         mme_pkg::REG_ROWS_A: cfg_rows_a = data;
         mme_pkg::REG_COLS_A: cfg_cols_a = data;
         mme_pkg::REG_ROWS_B: cfg_rows_b = data;
         mme_pkg::REG_COLS_B: cfg_cols_b = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_request(input logic [1:0] cmd, input logic [2:0] row,
                               input logic [2:0] col, input logic [31:0] value,
                               input logic given, input product_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, value, col, row};
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (given) expected_products.push_back(want);
      else predict_products(cmd, row, col, value);
      if (cmd == mme_pkg::CMD_WRITE_A) a_written[row * mme_pkg::MAX_DIM + col] = 1'b1;
      if (cmd == mme_pkg::CMD_WRITE_B) b_written[row * mme_pkg::MAX_DIM + col] = 1'b1;
      requests_sent++;
   endtask

   // fills whatever the product will read, then issues the compute request
   task automatic send_compute();
      int m, n, p, q;
      m = eff_dim(cfg_rows_a);
      n = eff_dim(cfg_cols_a);
      p = eff_dim(cfg_rows_b);
      q = eff_dim(cfg_cols_b);
      if (p == n) begin
         for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
               if (!a_written[i * mme_pkg::MAX_DIM + k])
                  send_request(mme_pkg::CMD_WRITE_A, 3'(i), 3'(k), rand_value(),
                               1'b0, '0);
         for (int k = 0; k < n; k++)
            for (int j = 0; j < q; j++)
               if (!b_written[k * mme_pkg::MAX_DIM + j])
                  send_request(mme_pkg::CMD_WRITE_B, 3'(k), 3'(j), rand_value(),
                               1'b0, '0);
      end
      send_request(mme_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom), $urandom, 1'b0, '0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // response side: stall stretches of random density, plus one long hold-off
   initial begin
      int taken, stretch, ready_pct;
      bit held;
      taken     = 0;
      stretch   = 0;
      ready_pct = 100;
      held      = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               stretch   = $urandom_range(4, 80);
               ready_pct = $urandom_range(0, 4) * 25;
            end
            stretch--;
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_products.size() == 0) begin
            $error("response with no request pending: tdata %h tuser %b tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            failed = 1'b1;
         end else begin
            want = expected_products.pop_front();
            if (rsp_tdata[2:0] !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_tdata[2:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[5:3] !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_tdata[5:3]);
               failed = 1'b1;
            end
            if (rsp_tdata[37:6] !== want.value) begin
               $error("product_value: expected %h, got %h", want.value, rsp_tdata[37:6]);
               failed = 1'b1;
            end
            if (rsp_tuser !== want.err) begin
               $error("dim_error: expected %b, got %b", want.err, rsp_tuser);
               failed = 1'b1;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int          m, n, p, q, phase_len;
      logic [1:0]  wcmd;
      step_type    s;
      product_type want;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;

      // sizes start at 1x1 after reset
      script.push_back(req_step(mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
      script.push_back(req_step(mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
      script.push_back(check_step(32'h0000_0001, 1'b0));
      script.push_back(req_step(CMD_UNUSED, 3'd0, 3'd0, 32'h1234_5678));
      script.push_back(check_step(32'h0000_0001, 1'b0));
      script.push_back(req_step(mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h8000_0000));
      script.push_back(req_step(mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'hFFFF_FFFF));
      script.push_back(check_step(32'h8000_0000, 1'b0));
      script.push_back(csr_step(mme_pkg::REG_COLS_A, 4'd2));
      script.push_back(check_step(32'h0000_0000, 1'b1));
      // spare index must not alias onto cols_a
      script.push_back(csr_step(REG_SPARE, 4'd1));
      script.push_back(check_step(32'h0000_0000, 1'b1));
      script.push_back(csr_step(mme_pkg::REG_ROWS_B, 4'd2));
      script.push_back(req_step(mme_pkg::CMD_WRITE_A, 3'd0, 3'd1, 32'h0000_0003));
      script.push_back(req_step(mme_pkg::CMD_WRITE_B, 3'd1, 3'd0, 32'h0000_0005));
      script.push_back(req_step(mme_pkg::CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF));
      // zero sizes act as one
      script.push_back(csr_step(mme_pkg::REG_ROWS_A, 4'd0));
      script.push_back(csr_step(mme_pkg::REG_COLS_A, 4'd0));
      script.push_back(csr_step(mme_pkg::REG_ROWS_B, 4'd0));
      script.push_back(csr_step(mme_pkg::REG_COLS_B, 4'd0));
      script.push_back(check_step(32'h8000_0000, 1'b0));
      // 15 clamps to 8, which differs from cols_a
      script.push_back(csr_step(mme_pkg::REG_ROWS_B, 4'd15));
      script.push_back(check_step(32'h0000_0000, 1'b1));
      script.push_back(req_step(mme_pkg::CMD_WRITE_A, 3'd7, 3'd7, 32'h5555_5555));
      script.push_back(req_step(mme_pkg::CMD_WRITE_B, 3'd7, 3'd7, 32'hAAAA_AAAA));
      script.push_back(req_step(mme_pkg::CMD_WRITE_A, 3'd7, 3'd0, 32'h0000_0000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < script.size(); i++) begin
         s = script[i];
         if (s.is_csr) begin
            wait_idle();
            write_csr(s.csr_sel, s.csr_data);
         end else begin
            want = '{row: 3'd0, col: 3'd0, value: s.want_value, err: s.want_err,
                     last: 1'b1};
            send_request(s.cmd, s.row, s.col, s.value, s.given, want);
         end
      end

      for (int phase = 0; requests_sent < TOTAL_REQUESTS; phase++) begin
         wait_idle();
         if (phase == 0) begin
            write_csr(mme_pkg::REG_ROWS_A, 4'd15);
            write_csr(mme_pkg::REG_COLS_A, 4'd15);
            write_csr(mme_pkg::REG_ROWS_B, 4'd15);
            write_csr(mme_pkg::REG_COLS_B, 4'd15);
         end else if (phase == 1) begin
            write_csr(mme_pkg::REG_ROWS_A, 4'd0);
            write_csr(mme_pkg::REG_COLS_A, 4'd0);
            write_csr(mme_pkg::REG_ROWS_B, 4'd0);
            write_csr(mme_pkg::REG_COLS_B, 4'd0);
         end else begin
            m = pick_dim();
            n = pick_dim();
            q = pick_dim();
            p = n;
            if ($urandom_range(0, 5) == 0)
               do p = pick_dim(); while (p == n);
            write_csr(mme_pkg::REG_ROWS_A, dim_code(m));
            write_csr(mme_pkg::REG_COLS_A, dim_code(n));
            write_csr(mme_pkg::REG_ROWS_B, dim_code(p));
            write_csr(mme_pkg::REG_COLS_B, dim_code(q));
            if ($urandom_range(0, 2) == 0)
               write_csr(3'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)),
                         4'($urandom));
         end
         m = eff_dim(cfg_rows_a);
         n = eff_dim(cfg_cols_a);
         p = eff_dim(cfg_rows_b);
         q = eff_dim(cfg_cols_b);
         phase_len = (phase == 0) ? 40 : $urandom_range(6, 30);
         repeat (phase_len) begin
            wcmd = ($urandom_range(0, 1) == 0) ? mme_pkg::CMD_WRITE_A : mme_pkg::CMD_WRITE_B;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  if (wcmd == mme_pkg::CMD_WRITE_A)
                     send_request(mme_pkg::CMD_WRITE_A, 3'($urandom_range(0, m - 1)),
                                  3'($urandom_range(0, n - 1)), rand_value(), 1'b0, '0);
                  else
                     send_request(mme_pkg::CMD_WRITE_B, 3'($urandom_range(0, p - 1)),
                                  3'($urandom_range(0, q - 1)), rand_value(), 1'b0, '0);
               end
               5: send_request(wcmd, 3'($urandom), 3'($urandom), rand_value(), 1'b0, '0);
               6: send_request(CMD_UNUSED, 3'($urandom), 3'($urandom), $urandom, 1'b0, '0);
               default: send_compute();
            endcase
         end
         send_compute();
      end

      wait_idle();
      if (failed)
         $display("FAIL");
      else
         $display("PASS");
      $finish;
   end

endmodule
